@@ hdl/bsvg_pkg.sv @@
package bsvg_pkg;

  localparam int FRAME_COLUMNS = 160;
  localparam logic signed [16:0] HALF_COLS = 17'(FRAME_COLUMNS / 2);

  localparam logic [7:0] MAGIC_BYTE     = 8'hA5;
  localparam logic [7:0] VERSION_BYTE   = 8'h01;
  localparam logic [7:0] TYPE_DETECTION = 8'h81;
  localparam logic [7:0] TYPE_ERROR     = 8'hE1;
  localparam int         FOUND_BIT      = 1;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_SERVO_ENABLE   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TARGET_AREA    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GAIN_DISTANCE  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GAIN_YAW       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GAIN_STRAFE    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_VELOCITY_LIMIT = 3'd5;
  localparam logic [CFG_AW-1:0] REG_YAW_RATE_LIMIT = 3'd6;
  localparam logic [CFG_AW-1:0] REG_STALE_TIMEOUT  = 3'd7;

  typedef struct packed {
    logic               servo_enable;
    logic [15:0]        target_area;
    logic signed [15:0] gain_distance;
    logic signed [15:0] gain_yaw;
    logic signed [15:0] gain_strafe;
    logic [14:0]        velocity_limit;
    logic [14:0]        yaw_rate_limit;
    logic [15:0]        stale_timeout_ms;
  } bsvg_cfg_t;

  typedef struct packed {
    logic               command;
    logic [31:0]        time_ms;
    logic               length_ok;
    logic [7:0]         magic;
    logic [7:0]         version;
    logic [7:0]         pkt_kind;
    logic [7:0]         status_bits;
    logic signed [15:0] blob_col;
    logic signed [15:0] blob_row;
    logic [15:0]        blob_area;
  } bsvg_item_t;

  // what the detection store reports for a tick
  typedef struct packed {
    logic               found;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0]        area;
    logic [31:0]        count;
  } bsvg_view_t;

  typedef struct packed {
    logic               target_found;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0]        area;
    logic               setpoint_valid;
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_strafe;
    logic signed [15:0] yaw_rate;
    logic [31:0]        accepted_count;
  } bsvg_result_t;

  // symmetric saturation of a shifted product to +/- lim
  function automatic logic signed [15:0] sat_lim(input logic signed [25:0] v,
                                                 input logic [14:0] lim);
    logic signed [25:0] lim_s;
    lim_s = $signed({11'b0, lim});
    if (v > lim_s) begin
      sat_lim = $signed({1'b0, lim});
    end else if (v < -lim_s) begin
      sat_lim = -$signed({1'b0, lim});
    end else begin
      sat_lim = v[15:0];
    end
  endfunction

endpackage

@@ hdl/blob_servo_velocity_guidance_unit.sv @@
// a request is taken into an input register; a tick's result then moves into
// the output register when that is free, and is held there while out_stall is high
// throughput: one request per cycle; the input register holds while a tick
// waits on a stalled result, a packet in the input register never waits
// reset (rst_n low, synchronous) restores register defaults and clears the
// stored detection, the packet counter and both valid flags
module blob_servo_velocity_guidance_unit
  import bsvg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [31:0]        in_time_ms,
  input  logic               in_length_ok,
  input  logic [7:0]         in_magic,
  input  logic [7:0]         in_version,
  input  logic [7:0]         in_pkt_kind,
  input  logic [7:0]         in_status_bits,
  input  logic signed [15:0] in_blob_col,
  input  logic signed [15:0] in_blob_row,
  input  logic [15:0]        in_blob_area,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_target_found,
  output logic signed [15:0] out_cx,
  output logic signed [15:0] out_cy,
  output logic [15:0]        out_area,
  output logic               out_setpoint_valid,
  output logic signed [15:0] out_vel_forward,
  output logic signed [15:0] out_vel_strafe,
  output logic signed [15:0] out_yaw_rate,
  output logic [31:0]        out_accepted_count
);

  bsvg_cfg_t    cfg;
  bsvg_view_t   view;
  bsvg_item_t   s1_item_r;
  logic         s1_valid_r;
  logic         out_valid_r;
  bsvg_result_t res_r;
  bsvg_result_t res_nxt;
  logic         out_free;
  logic         s1_go;
  logic         s1_tick;
  logic signed [15:0] vf, vs, yr;

  bsvg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_tick  = s1_valid_r && (s1_item_r.command == CMD_TICK);
  assign s1_go    = s1_valid_r && ((s1_item_r.command == CMD_PACKET) || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r.command     <= in_command;
      s1_item_r.time_ms     <= in_time_ms;
      s1_item_r.length_ok   <= in_length_ok;
      s1_item_r.magic       <= in_magic;
      s1_item_r.version     <= in_version;
      s1_item_r.pkt_kind    <= in_pkt_kind;
      s1_item_r.status_bits <= in_status_bits;
      s1_item_r.blob_col    <= in_blob_col;
      s1_item_r.blob_row    <= in_blob_row;
      s1_item_r.blob_area   <= in_blob_area;
    end
  end

  bsvg_det_store u_store (
    .clk              (clk),
    .rst_n            (rst_n),
    .pkt_en           (s1_valid_r && (s1_item_r.command == CMD_PACKET)),
    .item             (s1_item_r),
    .stale_timeout_ms (cfg.stale_timeout_ms),
    .view             (view)
  );

  bsvg_law u_law (
    .cfg         (cfg),
    .view        (view),
    .vel_forward (vf),
    .vel_strafe  (vs),
    .yaw_rate    (yr)
  );

  always_comb begin
    res_nxt.target_found   = view.found;
    res_nxt.cx             = view.found ? view.cx : -16'sd1;
    res_nxt.cy             = view.found ? view.cy : -16'sd1;
    res_nxt.area           = view.found ? view.area : 16'd0;
    res_nxt.setpoint_valid = cfg.servo_enable;
    res_nxt.vel_forward    = vf;
    res_nxt.vel_strafe     = vs;
    res_nxt.yaw_rate       = yr;
    res_nxt.accepted_count = view.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_tick) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target_found   = res_r.target_found;
  assign out_cx             = res_r.cx;
  assign out_cy             = res_r.cy;
  assign out_area           = res_r.area;
  assign out_setpoint_valid = res_r.setpoint_valid;
  assign out_vel_forward    = res_r.vel_forward;
  assign out_vel_strafe     = res_r.vel_strafe;
  assign out_yaw_rate       = res_r.yaw_rate;
  assign out_accepted_count = res_r.accepted_count;

`ifndef SYNTHESIS
  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.setpoint_valid) |->
      (res_r.vel_forward == 16'sd0) && (res_r.vel_strafe == 16'sd0) &&
      (res_r.yaw_rate == 16'sd0))
    else $error("velocity issued while disabled");

  a_lost_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.target_found) |->
      (res_r.cx == -16'sd1) && (res_r.cy == -16'sd1) && (res_r.area == 16'd0) &&
      (res_r.vel_forward == 16'sd0))
    else $error("target fields not defaulted when no target");

  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_tick && out_valid_r && out_stall) |-> in_stall)
    else $error("new request taken while a tick waits on the output");
`endif

endmodule

@@ hdl/bsvg_cfg_regs.sv @@
module bsvg_cfg_regs
  import bsvg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output bsvg_cfg_t         cfg
);

  bsvg_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SERVO_ENABLE:   cfg_nxt.servo_enable     = cfg_wdata[0];
        REG_TARGET_AREA:    cfg_nxt.target_area      = cfg_wdata;
        REG_GAIN_DISTANCE:  cfg_nxt.gain_distance    = $signed(cfg_wdata);
        REG_GAIN_YAW:       cfg_nxt.gain_yaw         = $signed(cfg_wdata);
        REG_GAIN_STRAFE:    cfg_nxt.gain_strafe      = $signed(cfg_wdata);
        REG_VELOCITY_LIMIT: cfg_nxt.velocity_limit   = cfg_wdata[14:0];
        REG_YAW_RATE_LIMIT: cfg_nxt.yaw_rate_limit   = cfg_wdata[14:0];
        REG_STALE_TIMEOUT:  cfg_nxt.stale_timeout_ms = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_enable     <= 1'b0;
      cfg_r.target_area      <= 16'd1500;
      cfg_r.gain_distance    <= 16'sd154;
      cfg_r.gain_yaw         <= 16'sd7680;
      cfg_r.gain_strafe      <= 16'sd0;
      cfg_r.velocity_limit   <= 15'd300;
      cfg_r.yaw_rate_limit   <= 15'd4000;
      cfg_r.stale_timeout_ms <= 16'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/bsvg_det_store.sv @@
module bsvg_det_store
  import bsvg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pkt_en,
  input  bsvg_item_t item,
  input  logic [15:0] stale_timeout_ms,
  output bsvg_view_t view
);

  logic               have_r;
  logic [31:0]        det_time_r;
  logic               is_det_r;
  logic               found_bit_r;
  logic signed [15:0] cx_r;
  logic signed [15:0] cy_r;
  logic [15:0]        area_r;
  logic [31:0]        cnt_r;

  logic        pkt_ok;
  logic        pkt_take;
  logic [31:0] age;
  logic        fresh;

  assign pkt_ok = item.length_ok && (item.magic == MAGIC_BYTE) &&
                  (item.version == VERSION_BYTE) &&
                  ((item.pkt_kind == TYPE_DETECTION) || (item.pkt_kind == TYPE_ERROR));
  assign pkt_take = pkt_en && pkt_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      det_time_r  <= '0;
      is_det_r    <= 1'b0;
      found_bit_r <= 1'b0;
      cx_r        <= '0;
      cy_r        <= '0;
      area_r      <= '0;
      cnt_r       <= '0;
    end else if (pkt_take) begin
      have_r      <= 1'b1;
      det_time_r  <= item.time_ms;
      is_det_r    <= (item.pkt_kind == TYPE_DETECTION);
      found_bit_r <= item.status_bits[FOUND_BIT];
      cx_r        <= item.blob_col;
      cy_r        <= item.blob_row;
      area_r      <= item.blob_area;
      cnt_r       <= cnt_r + 32'd1;
    end
  end

  // age wraps modulo 2^32
  assign age   = item.time_ms - det_time_r;
  assign fresh = have_r && (age <= {16'b0, stale_timeout_ms});

  assign view.found = fresh && is_det_r && found_bit_r;
  assign view.cx    = cx_r;
  assign view.cy    = cy_r;
  assign view.area  = area_r;
  assign view.count = cnt_r;

`ifndef SYNTHESIS
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_take |=> cnt_r == $past(cnt_r) + 32'd1)
    else $error("request counter did not advance on an accepted packet");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pkt_take |=> $stable(cnt_r) && $stable(det_time_r))
    else $error("detection state changed without an accepted packet");
`endif

endmodule

@@ hdl/bsvg_law.sv @@
module bsvg_law
  import bsvg_pkg::*;
(
  input  bsvg_cfg_t          cfg,
  input  bsvg_view_t         view,
  output logic signed [15:0] vel_forward,
  output logic signed [15:0] vel_strafe,
  output logic signed [15:0] yaw_rate
);

  logic signed [16:0] ex;
  logic signed [16:0] area_err;
  logic signed [32:0] p_fwd;
  logic signed [32:0] p_str;
  logic signed [32:0] p_yaw;
  logic signed [33:0] n_str;
  logic signed [33:0] n_yaw;
  logic               active;

  assign ex       = $signed({view.cx[15], view.cx}) - HALF_COLS;
  assign area_err = $signed({1'b0, cfg.target_area}) - $signed({1'b0, view.area});

  assign p_fwd = cfg.gain_distance * area_err;
  assign p_str = cfg.gain_strafe * ex;
  assign p_yaw = cfg.gain_yaw * ex;

  // negate before the floor shift
  assign n_str = -$signed({p_str[32], p_str});
  assign n_yaw = -$signed({p_yaw[32], p_yaw});

  assign active = cfg.servo_enable && view.found;

  assign vel_forward = active ?
    sat_lim($signed({p_fwd[32], p_fwd[32:8]}), cfg.velocity_limit) : 16'sd0;
  assign vel_strafe  = active ? sat_lim(n_str[33:8], cfg.velocity_limit) : 16'sd0;
  assign yaw_rate    = active ? sat_lim(n_yaw[33:8], cfg.yaw_rate_limit) : 16'sd0;

endmodule
